### hdl/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 64;
    localparam int POS_W  = 4;
    localparam int TERM_W = 3;

    localparam logic OPCODE_DATA    = 1'b0;
    localparam logic OPCODE_RESTART = 1'b1;

    localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;

    localparam logic [3:0] FRAME_OP_TEXT = 4'h1;
    localparam logic [6:0] LEN7_EXT16    = 7'd126;
    localparam logic [6:0] LEN7_EXT64    = 7'd127;

    localparam logic [TERM_W-1:0] TERM_LAST = 3'd3;

    localparam logic [POS_W-1:0] HDR_POS_FIRST = 4'd0;
    localparam logic [POS_W-1:0] HDR_POS_LEN   = 4'd1;
    localparam logic [POS_W-1:0] HDR_POS_EXT   = 4'd2;
    localparam logic [POS_W-1:0] HDR_END_16    = 4'd4;
    localparam logic [POS_W-1:0] HDR_END_64    = 4'd10;

    typedef enum logic [1:0] {
        LEN_MODE_7  = 2'd0,
        LEN_MODE_16 = 2'd1,
        LEN_MODE_64 = 2'd2
    } len_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic              payload_last;
        logic              empty_frame;
        logic              handshake_seen;
        logic              stream_blocked;
    } wsd_result_t;

endpackage

### hdl/wsd_parser.sv
`timescale 1ns / 1ps

module wsd_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step_en,
    input  logic                       opcode,
    input  logic [wsd_pkg::BYTE_W-1:0] rx_byte,
    output wsd_pkg::wsd_result_t       result
);
    import wsd_pkg::*;

    logic [TERM_W-1:0] term_reg, term_next;
    logic              hs_reg, hs_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    len_mode_t         mode_reg, mode_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic              blocked_reg, blocked_next;

    logic [BYTE_W-1:0] want;
    logic [6:0]        len7;
    logic [LEN_W-1:0]  acc_shift;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  hdr_end;

    assign want      = term_reg[0] ? LF_BYTE : CR_BYTE;
    assign len7      = rx_byte[6:0];
    assign acc_shift = {acc_reg[LEN_W-BYTE_W-1:0], rx_byte};
    assign pos_inc   = pos_reg + 1'b1;
    assign hdr_end   = (mode_reg == LEN_MODE_16) ? HDR_END_16 : HDR_END_64;

    always_comb begin
        term_next    = term_reg;
        hs_next      = hs_reg;
        pos_next     = pos_reg;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        remain_next  = remain_reg;
        blocked_next = blocked_reg;
        result       = '0;
        if (opcode == OPCODE_RESTART) begin
            term_next    = '0;
            hs_next      = 1'b0;
            pos_next     = HDR_POS_FIRST;
            mode_next    = LEN_MODE_7;
            acc_next     = '0;
            remain_next  = '0;
            blocked_next = 1'b0;
        end else if (blocked_reg) begin
            // stalled until connection restart
        end else if (!hs_reg) begin
            if (rx_byte == want) begin
                if (term_reg == TERM_LAST) begin
                    term_next = '0;
                    hs_next   = 1'b1;
                end else begin
                    term_next = term_reg + 1'b1;
                end
            end else if (rx_byte == CR_BYTE) begin
                term_next = TERM_W'(1);
            end else begin
                term_next = '0;
            end
        end else if (remain_reg != '0) begin
            result.payload_byte  = rx_byte;
            result.payload_valid = 1'b1;
            result.payload_last  = (remain_reg == LEN_W'(1));
            remain_next          = remain_reg - 1'b1;
        end else if (pos_reg == HDR_POS_FIRST) begin
            if (rx_byte[3:0] != FRAME_OP_TEXT) begin
                blocked_next = 1'b1;
            end else begin
                pos_next = HDR_POS_LEN;
            end
        end else if (pos_reg == HDR_POS_LEN) begin
            if (len7 == LEN7_EXT16) begin
                mode_next = LEN_MODE_16;
                acc_next  = '0;
                pos_next  = HDR_POS_EXT;
            end else if (len7 == LEN7_EXT64) begin
                mode_next = LEN_MODE_64;
                acc_next  = '0;
                pos_next  = HDR_POS_EXT;
            end else begin
                pos_next           = HDR_POS_FIRST;
                mode_next          = LEN_MODE_7;
                acc_next           = '0;
                remain_next        = LEN_W'(len7);
                result.empty_frame = (len7 == 7'd0);
            end
        end else begin
            acc_next = acc_shift;
            pos_next = pos_inc;
            if (pos_inc >= hdr_end) begin
                pos_next           = HDR_POS_FIRST;
                mode_next          = LEN_MODE_7;
                acc_next           = '0;
                remain_next        = acc_shift;
                result.empty_frame = (acc_shift == '0);
            end
        end
        result.handshake_seen = hs_next;
        result.stream_blocked = blocked_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg    <= '0;
            hs_reg      <= 1'b0;
            pos_reg     <= HDR_POS_FIRST;
            mode_reg    <= LEN_MODE_7;
            acc_reg     <= '0;
            remain_reg  <= '0;
            blocked_reg <= 1'b0;
        end else if (step_en) begin
            term_reg    <= term_next;
            hs_reg      <= hs_next;
            pos_reg     <= pos_next;
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            remain_reg  <= remain_next;
            blocked_reg <= blocked_next;
        end
    end

endmodule

### hdl/websocket_text_frame_deframer.sv
`timescale 1ns / 1ps

// receive-side deframer for a websocket client, one byte per word
// input channel (s_): s_opcode 0 carries a received byte in s_rx_byte,
//   s_opcode 1 restarts the connection and clears all parser state
// result channel (m_): exactly one result word per input word, in order:
//   payload byte with valid and last marks, empty frame flag, and the
//   handshake-seen and stream-blocked status after that word
// the http upgrade response is dropped up to its blank line, then text
// frames are parsed; a non-text frame opcode blocks until a restart
// each word is held in the input register, stepped through the parser and its
//   result word is presented from the result register
// throughput: one word per cycle while the receiver does not stall, set by the parser step
//   between the input register and the result register
// a stalled receiver holds the result register; one more word can still
//   be taken into the input register before s_ready drops
// reset (aresetn low, synchronous) empties both registers and clears state

module websocket_text_frame_deframer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [wsd_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [wsd_pkg::BYTE_W-1:0] m_payload_byte,
    output logic                       m_payload_valid,
    output logic                       m_payload_last,
    output logic                       m_empty_frame,
    output logic                       m_handshake_seen,
    output logic                       m_stream_blocked
);
    import wsd_pkg::*;

    logic              in_valid_reg;
    logic              in_opcode_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    wsd_result_t       out_reg;
    wsd_result_t       step_result;
    logic              advance;
    logic              step_en;

    assign advance = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    wsd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .opcode  (in_opcode_reg),
        .rx_byte (in_byte_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_opcode_reg <= s_opcode;
            in_byte_reg   <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_reg <= step_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_payload_valid  = out_reg.payload_valid;
    assign m_payload_last   = out_reg.payload_last;
    assign m_empty_frame    = out_reg.empty_frame;
    assign m_handshake_seen = out_reg.handshake_seen;
    assign m_stream_blocked = out_reg.stream_blocked;

endmodule

### bench/wsd_checker.sv
`timescale 1ns / 1ps

module wsd_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [wsd_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [wsd_pkg::BYTE_W-1:0] m_payload_byte,
    input  logic                       m_payload_valid,
    input  logic                       m_payload_last,
    input  logic                       m_empty_frame,
    input  logic                       m_handshake_seen,
    input  logic                       m_stream_blocked,
    output int                         fail_count,
    output int                         pending
);
    import wsd_pkg::*;

    localparam int MAX_REPORTS = 200;

    logic [TERM_W-1:0] term_cnt;
    logic              hs_done;
    logic [POS_W-1:0]  hdr_pos;
    len_mode_t         len_mode;
    logic [LEN_W-1:0]  len_acc;
    logic [LEN_W-1:0]  remaining;
    logic              blocked;

    wsd_result_t result_q [$];
    wsd_result_t want_word;
    wsd_result_t got_word;
    int          n_fail = 0;
    int          n_pending = 0;

    assign fail_count = n_fail;
    assign pending    = n_pending;

    function automatic void clear_state();
        term_cnt  = '0;
        hs_done   = 1'b0;
        hdr_pos   = HDR_POS_FIRST;
        len_mode  = LEN_MODE_7;
        len_acc   = '0;
        remaining = '0;
        blocked   = 1'b0;
    endfunction

    // closes a header, returns 1 for a zero-length frame
    function automatic logic start_payload(input logic [LEN_W-1:0] len);
        hdr_pos   = HDR_POS_FIRST;
        len_mode  = LEN_MODE_7;
        len_acc   = '0;
        remaining = len;
        return len == '0;
    endfunction

    function automatic wsd_result_t deframe_word(input logic op, input logic [BYTE_W-1:0] b);
        wsd_result_t      r;
        logic [BYTE_W-1:0] want;
        logic [POS_W-1:0]  hdr_end;
        r = '0;
        if (op == OPCODE_RESTART) begin
            clear_state();
        end else if (blocked) begin
            // ignored until restart
        end else if (!hs_done) begin
            want = term_cnt[0] ? LF_BYTE : CR_BYTE;
            if (b == want) begin
                term_cnt = term_cnt + 1'b1;
            end else if (b == CR_BYTE) begin
                term_cnt = 3'd1;
            end else begin
                term_cnt = '0;
            end
            if (term_cnt > TERM_LAST) begin
                term_cnt = '0;
                hs_done  = 1'b1;
            end
        end else if (remaining != '0) begin
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            r.payload_last  = (remaining == 64'd1);
            remaining       = remaining - 1'b1;
        end else if (hdr_pos == HDR_POS_FIRST) begin
            if (b[3:0] != FRAME_OP_TEXT) begin
                blocked = 1'b1;
            end else begin
                hdr_pos = HDR_POS_LEN;
            end
        end else if (hdr_pos == HDR_POS_LEN) begin
            if (b[6:0] == LEN7_EXT16) begin
                len_mode = LEN_MODE_16;
                len_acc  = '0;
                hdr_pos  = HDR_POS_EXT;
            end else if (b[6:0] == LEN7_EXT64) begin
                len_mode = LEN_MODE_64;
                len_acc  = '0;
                hdr_pos  = HDR_POS_EXT;
            end else begin
                r.empty_frame = start_payload(LEN_W'(b[6:0]));
            end
        end else begin
            hdr_end = (len_mode == LEN_MODE_16) ? HDR_END_16 : HDR_END_64;
            len_acc = {len_acc[LEN_W-BYTE_W-1:0], b};
            hdr_pos = hdr_pos + 1'b1;
            if (hdr_pos >= hdr_end) begin
                r.empty_frame = start_payload(len_acc);
            end
        end
        r.handshake_seen = hs_done;
        r.stream_blocked = blocked;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            result_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got_word = '{m_payload_byte, m_payload_valid, m_payload_last, m_empty_frame,
                             m_handshake_seen, m_stream_blocked};
                if (result_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS) begin
                        $display("%0t: result word expected none actual %0h", $time, got_word);
                    end
                end else begin
                    want_word = result_q.pop_front();
                    check_field("payload_byte", want_word.payload_byte, got_word.payload_byte);
                    check_field("payload_valid", 8'(want_word.payload_valid),
                                8'(got_word.payload_valid));
                    check_field("payload_last", 8'(want_word.payload_last),
                                8'(got_word.payload_last));
                    check_field("empty_frame", 8'(want_word.empty_frame),
                                8'(got_word.empty_frame));
                    check_field("handshake_seen", 8'(want_word.handshake_seen),
                                8'(got_word.handshake_seen));
                    check_field("stream_blocked", 8'(want_word.stream_blocked),
                                8'(got_word.stream_blocked));
                end
            end
            if (s_valid && s_ready) begin
                result_q.push_back(deframe_word(s_opcode, s_rx_byte));
            end
        end
        n_pending = result_q.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import wsd_pkg::*;

    localparam int N_WORDS     = 1950;
    localparam int CALM_AFTER  = 1750;
    localparam int IDLE_LIMIT  = 1000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_opcode = OPCODE_DATA;
    logic [BYTE_W-1:0] s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_payload_byte;
    logic              m_payload_valid;
    logic              m_payload_last;
    logic              m_empty_frame;
    logic              m_handshake_seen;
    logic              m_stream_blocked;

    int   fail_count;
    int   pending;
    int   n_words = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    logic calm = 1'b0;

    logic [BYTE_W-1:0] directed_q [$];

    always #4 aclk = ~aclk;

    websocket_text_frame_deframer i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload_byte   (m_payload_byte),
        .m_payload_valid  (m_payload_valid),
        .m_payload_last   (m_payload_last),
        .m_empty_frame    (m_empty_frame),
        .m_handshake_seen (m_handshake_seen),
        .m_stream_blocked (m_stream_blocked)
    );

    wsd_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_payload_byte   (m_payload_byte),
        .m_payload_valid  (m_payload_valid),
        .m_payload_last   (m_payload_last),
        .m_empty_frame    (m_empty_frame),
        .m_handshake_seen (m_handshake_seen),
        .m_stream_blocked (m_stream_blocked),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // receiver stalls in short bursts
    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic op, input logic [BYTE_W-1:0] b);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic put(input logic [BYTE_W-1:0] b);
        send_word(OPCODE_DATA, b);
        n_words++;
    endtask

    // one text frame; huge lengths over 40 are cut short and leave the parser mid-payload
    task automatic send_frame(input logic huge, output logic cut);
        logic [LEN_W-1:0] len;
        int               form;
        int               n_send;
        form = $urandom_range(0, 2);
        case (form)
            0: len = huge ? LEN_W'($urandom_range(40, 125)) : LEN_W'($urandom_range(0, 12));
            1: len = huge ? LEN_W'(16'($urandom)) : LEN_W'($urandom_range(0, 24));
            default: len = huge ? {$urandom, $urandom} : LEN_W'($urandom_range(0, 24));
        endcase
        put({4'($urandom), FRAME_OP_TEXT});
        case (form)
            0: put({1'($urandom), len[6:0]});
            1: put({1'($urandom), LEN7_EXT16});
            default: put({1'($urandom), LEN7_EXT64});
        endcase
        if (form == 1) begin
            put(len[15:8]);
            put(len[7:0]);
        end else if (form == 2) begin
            for (int k = 7; k >= 0; k--) put(len[8*k +: 8]);
        end
        n_send = (huge && len > 64'd40) ? $urandom_range(3, 40) : int'(len);
        repeat (n_send) put(8'($urandom));
        cut = LEN_W'(n_send) < len;
    endtask

    task automatic run_connection();
        int                n_noise;
        int                n_frames;
        int                pick;
        logic [BYTE_W-1:0] b;
        logic              cut;
        send_word(OPCODE_RESTART, 8'($urandom));
        n_words++;
        n_noise = $urandom_range(0, 10);
        repeat (n_noise) begin
            pick = $urandom_range(0, 5);
            b = (pick == 0) ? CR_BYTE : (pick == 1) ? LF_BYTE : 8'($urandom);
            put(b);
        end
        if ($urandom_range(0, 11) == 0) return;
        put(CR_BYTE);
        put(LF_BYTE);
        put(CR_BYTE);
        put(LF_BYTE);
        n_frames = $urandom_range(1, 8);
        for (int i = 0; i < n_frames; i++) begin
            pick = $urandom_range(0, 24);
            if (pick == 0) begin
                b = 8'($urandom);
                if (b[3:0] == FRAME_OP_TEXT) b[3:0] = ~FRAME_OP_TEXT;
                put(b);
                repeat ($urandom_range(0, 4)) send_word(OPCODE_DATA, 8'($urandom));
                return;
            end
            send_frame(pick == 1, cut);
            if (cut) return;
        end
    endtask

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // mismatched cr restarts the match, then frames of each length form and a non-text frame that blocks
        directed_q = '{CR_BYTE, CR_BYTE, LF_BYTE, CR_BYTE, LF_BYTE,
                       8'h81, 8'h02, 8'h00, 8'hFF,
                       8'hF1, {1'b1, LEN7_EXT64}, 8'h00, 8'h00, 8'h00, 8'h00,
                       8'h00, 8'h00, 8'h00, 8'h00,
                       8'h01, {1'b0, LEN7_EXT16}, 8'h00, 8'h01, 8'hAB,
                       8'h82, 8'h5A};
        foreach (directed_q[i]) put(directed_q[i]);
        send_word(OPCODE_RESTART, 8'hFF);
        n_words++;

        while (n_words < N_WORDS) begin
            calm = (n_words > CALM_AFTER);
            run_connection();
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
